/* sv/assert_macros.svh */
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/ptil_pkg.sv */
package ptil_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KindWrite = 2'd0,
    KindStart = 2'd1,
    KindStop  = 2'd2,
    KindFail  = 2'd3
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgAddressLimit = 2'd0;
  localparam logic [1:0] CfgWordLimit    = 2'd1;
  localparam logic [1:0] CfgBlockLimit   = 2'd2;

  localparam int unsigned LimitWidth = 17;
  localparam logic [LimitWidth-1:0] LimitMax = 17'd65536;

  // Tape words and masks.
  localparam logic [17:0] HdrLoader   = 18'o327751;
  localparam logic [17:0] HdrBin      = 18'o730002;
  localparam logic [17:0] HdrAm1A     = 18'o724074;
  localparam logic [17:0] HdrAm1B     = 18'o760000;
  localparam logic [17:0] OpAm1Mask   = 18'o600000;
  localparam logic [17:0] OpBinMask   = 18'o770000;
  localparam logic [17:0] Am1AddrMask = 18'o177777;
  localparam logic [17:0] OpDio       = 18'o320000;
  localparam logic [17:0] OpAm1Start  = 18'o400000;
  localparam logic [17:0] OpJmp       = 18'o600000;
  localparam logic [7:0]  MarkBit     = 8'o200;
  localparam logic [7:0]  CharMask    = 8'o077;

  typedef struct packed {
    logic       action;
    logic [7:0] tape_char;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [17:0] data;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [LimitWidth-1:0] address_limit;
    logic [LimitWidth-1:0] word_limit;
    logic [LimitWidth-1:0] block_limit;
  } limits_t;

  // A register written above the top of memory acts as the top.
  function automatic logic [LimitWidth-1:0] cap_limit(input logic [LimitWidth-1:0] v);
    cap_limit = (v > LimitMax) ? LimitMax : v;
  endfunction

endpackage

/* sv/ptil_parser.sv */
module ptil_parser import ptil_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  in_t     item_i,
  input  limits_t limits_i,
  output logic    res_valid_o,
  output out_t    res_o
);

  localparam logic [3:0] PhHdr1    = 4'd0;
  localparam logic [3:0] PhHdr2    = 4'd1;
  localparam logic [3:0] PhLdrA    = 4'd2;
  localparam logic [3:0] PhLdrB    = 4'd3;
  localparam logic [3:0] PhCtrl    = 4'd4;
  localparam logic [3:0] PhEndAddr = 4'd5;
  localparam logic [3:0] PhData    = 4'd6;
  localparam logic [3:0] PhCksum   = 4'd7;

  localparam logic FmtAm1 = 1'b0;
  localparam logic FmtBin = 1'b1;

  logic [3:0]  phase_q, phase_d;
  logic        fmt_q, fmt_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [17:0] asm_q, asm_d;
  logic [16:0] cur_q, cur_d;
  logic [17:0] end_q, end_d;
  logic [16:0] words_q, words_d;
  logic [16:0] blocks_q, blocks_d;

  logic [17:0] word;
  logic        ctrl_en;
  logic        done;

  function automatic out_t mk_res(input kind_e k, input logic [15:0] a,
                                  input logic [17:0] d);
    out_t r;
    r.kind    = k;
    r.address = a;
    r.data    = d;
    r.last    = (k != KindWrite);
    mk_res = r;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    fmt_d       = fmt_q;
    cnt_d       = cnt_q;
    asm_d       = asm_q;
    cur_d       = cur_q;
    end_d       = end_q;
    words_d     = words_q;
    blocks_d    = blocks_q;
    res_valid_o = 1'b0;
    res_o       = mk_res(KindWrite, 16'd0, 18'd0);
    ctrl_en     = 1'b0;
    word        = {asm_q[11:0], item_i.tape_char[5:0] & CharMask[5:0]};

    if (step_i) begin
      if (item_i.action) begin
        res_valid_o = 1'b1;
        res_o       = mk_res(KindFail, 16'd0, 18'd0);
      end else if ((item_i.tape_char & MarkBit) != 8'd0) begin
        if (cnt_q < 2'd2) begin
          cnt_d = cnt_q + 2'd1;
          asm_d = word;
        end else begin
          cnt_d = 2'd0;
          asm_d = 18'd0;
          unique case (phase_q)
            PhHdr1: begin
              if (word == HdrLoader) begin
                phase_d = PhHdr2;
              end else if ((word & OpAm1Mask) == 18'd0) begin
                fmt_d   = FmtAm1;
                phase_d = PhCtrl;
                ctrl_en = 1'b1;
              end else begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end
            end
            PhHdr2: begin
              if (word == HdrBin) begin
                fmt_d   = FmtBin;
                phase_d = PhLdrA;
              end else if (word == HdrAm1A || word == HdrAm1B) begin
                fmt_d   = FmtAm1;
                phase_d = PhLdrA;
              end else begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end
            end
            PhLdrA: phase_d = ((word & OpBinMask) == OpJmp) ? PhCtrl : PhLdrB;
            PhLdrB: phase_d = PhLdrA;
            PhCtrl: ctrl_en = 1'b1;
            PhEndAddr: begin
              end_d = (fmt_q == FmtAm1) ? word : {6'd0, word[11:0]};
              if (blocks_q >= limits_i.block_limit) begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end else begin
                blocks_d = blocks_q + 17'd1;
                phase_d  = PhData;
              end
            end
            PhData: begin
              if (cur_q >= limits_i.address_limit || words_q >= limits_i.word_limit) begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end else begin
                words_d = words_q + 17'd1;
                cur_d   = cur_q + 17'd1;
                if ({1'b0, cur_d} == end_q) begin
                  phase_d = (fmt_q == FmtBin) ? PhCksum : PhCtrl;
                end
                res_valid_o = 1'b1;
                res_o       = mk_res(KindWrite, cur_q[15:0], word);
              end
            end
            PhCksum: phase_d = PhCtrl;
            default: begin
              res_valid_o = 1'b1;
              res_o       = mk_res(KindFail, 16'd0, 18'd0);
            end
          endcase

          if (ctrl_en) begin
            if (fmt_d == FmtAm1) begin
              priority if ((word & OpAm1Mask) == 18'd0) begin
                cur_d   = {1'b0, word[15:0] & Am1AddrMask[15:0]};
                phase_d = PhEndAddr;
              end else if ((word & OpAm1Mask) == OpAm1Start) begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindStart, word[15:0] & Am1AddrMask[15:0], 18'd0);
              end else if ((word & OpAm1Mask) == OpAm1Mask) begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindStop, 16'd0, 18'd0);
              end else begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end
            end else begin
              priority if ((word & OpBinMask) == OpDio) begin
                cur_d   = {5'd0, word[11:0]};
                phase_d = PhEndAddr;
              end else if ((word & OpBinMask) == OpJmp) begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindStart, {4'd0, word[11:0]}, 18'd0);
              end else begin
                res_valid_o = 1'b1;
                res_o       = mk_res(KindFail, 16'd0, 18'd0);
              end
            end
          end
        end
      end
    end

    // A final result returns the parser to its reset state.
    done = res_valid_o && (res_o.kind != KindWrite);
    if (done) begin
      phase_d  = PhHdr1;
      fmt_d    = FmtAm1;
      cnt_d    = 2'd0;
      asm_d    = 18'd0;
      cur_d    = 17'd0;
      end_d    = 18'd0;
      words_d  = 17'd0;
      blocks_d = 17'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr1;
      fmt_q    <= FmtAm1;
      cnt_q    <= 2'd0;
      asm_q    <= 18'd0;
      cur_q    <= 17'd0;
      end_q    <= 18'd0;
      words_q  <= 17'd0;
      blocks_q <= 17'd0;
    end else begin
      phase_q  <= phase_d;
      fmt_q    <= fmt_d;
      cnt_q    <= cnt_d;
      asm_q    <= asm_d;
      cur_q    <= cur_d;
      end_q    <= end_d;
      words_q  <= words_d;
      blocks_q <= blocks_d;
    end
  end

endmodule

/* sv/paper_tape_image_loader.sv */
// A result is registered in the output register and appears there in the cycle
// after the tape character (or end-of-tape transaction) that causes it is accepted.
// Throughput: one input transaction per cycle; input is only held back while the
// output register is full and not being taken.
// Reset (asynchronous, active low) puts the parser in its header phase and sets
// all three limits to 65536.
module paper_tape_image_loader import ptil_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [LimitWidth-1:0] cfg_value_i
);

  // Limit registers hold the raw written value; capping happens on the way
  // to the parser so that a value above the memory size acts as that size.
  logic [LimitWidth-1:0] addr_lim_q, word_lim_q, block_lim_q;
  limits_t               limits;

  logic   accept;
  logic   res_valid;
  out_t   res;
  logic   out_valid_q, out_valid_d;
  out_t   out_data_q;

  // Configuration is always taken; an index past the three registers is
  // silently dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_lim_q  <= LimitMax;
      word_lim_q  <= LimitMax;
      block_lim_q <= LimitMax;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAddressLimit: addr_lim_q  <= cfg_value_i;
        CfgWordLimit:    word_lim_q  <= cfg_value_i;
        CfgBlockLimit:   block_lim_q <= cfg_value_i;
        default: ;
      endcase
    end
  end

  assign limits.address_limit = cap_limit(addr_lim_q);
  assign limits.word_limit    = cap_limit(word_lim_q);
  assign limits.block_limit   = cap_limit(block_lim_q);

  // The output register parts the two sides: a new character is taken
  // whenever the register is empty or its transaction completes this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ptil_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .item_i      (in_data_i),
    .limits_i    (limits),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/ptil_checker.sv */
`include "assert_macros.svh"

module ptil_checker import ptil_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_t                   in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_t                  out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [1:0]            cfg_index_i,
  input logic [LimitWidth-1:0] cfg_value_i
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `ASSERT_IMP(a_last_kind, clk_i, rst_ni, out_valid_o, out_data_o.last == (out_data_o.kind != KindWrite))
  `ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `ASSERT_NXT(a_eot_fails, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.action, out_valid_o && out_data_o.kind == KindFail)

endmodule

bind paper_tape_image_loader ptil_checker u_ptil_checker (.*);
